// File: rtl/pen_pkg.sv
// Shared constants and codes for the polygon edge normal and bounds block.
`default_nettype none
package pen_pkg;
   localparam int COORD_WIDTH      = 32;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int QUEUE_DEPTH      = 2;

   localparam int VERTEX_WIDTH     = 32;
   localparam int NORMAL_WIDTH     = 16;
   localparam int BOX_WIDTH        = 32;
   localparam int REQ_TDATA_WIDTH  = 2 * VERTEX_WIDTH;
   localparam int RSP_TDATA_WIDTH  = 2 * NORMAL_WIDTH + 4 * BOX_WIDTH;

   // Result kinds, also used as the job kind in the queue
   localparam logic KIND_NORMAL = 1'b0;
   localparam logic KIND_BOUNDS = 1'b1;
endpackage
`default_nettype wire

// File: rtl/pen_queue.sv
// Small register queue between the vertex front end and the normal unit.
`default_nettype none
module pen_queue #(
   parameter int Width = 8,
   parameter int Depth = pen_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [Width-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [Width-1:0] pop_data
);
   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   logic [Width-1:0]  store_ff [Depth];
   logic [PtrWidth:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth:0] rd_ptr_ff, rd_ptr_in;
   logic              full, empty;

   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign full       = (wr_ptr_ff[PtrWidth-1:0] == rd_ptr_ff[PtrWidth-1:0]) && !empty;
   assign push_ready = !full;
   assign pop_valid  = !empty;
   assign pop_data   = store_ff[rd_ptr_ff[PtrWidth-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ready && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && !full) begin
         store_ff[wr_ptr_ff[PtrWidth-1:0]] <= push_data;
      end
   end
endmodule
`default_nettype wire

// File: rtl/pen_front.sv
// Vertex front end: tracks polygon state and issues edge and bounds jobs.
`default_nettype none
module pen_front #(
   parameter int CoordWidth = pen_pkg::COORD_WIDTH,
   localparam int FieldWidth = CoordWidth + 1,
   localparam int JobWidth = 4 * FieldWidth + 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic signed [CoordWidth-1:0] vertex_x,
   input  wire logic signed [CoordWidth-1:0] vertex_y,
   input  wire logic                         is_last_vertex,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output logic             [JobWidth-1:0]   push_data
);
   localparam logic signed [CoordWidth-1:0] MostPos = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam logic signed [CoordWidth-1:0] MostNeg = {1'b1, {(CoordWidth-1){1'b0}}};

   logic signed [CoordWidth-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CoordWidth-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic        [1:0]            count_ff, count_in;
   logic signed [CoordWidth-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [CoordWidth-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic                         pend_edge_ff, pend_edge_in;
   logic                         pend_close_ff, pend_close_in;
   logic                         pend_box_ff, pend_box_in;
   logic signed [FieldWidth-1:0] edge_dx_ff, edge_dx_in, edge_dy_ff, edge_dy_in;
   logic signed [FieldWidth-1:0] close_dx_ff, close_dx_in, close_dy_ff, close_dy_in;
   logic signed [CoordWidth-1:0] box_l_ff, box_l_in, box_r_ff, box_r_in;
   logic signed [CoordWidth-1:0] box_b_ff, box_b_in, box_t_ff, box_t_in;

   logic                         accept;
   logic signed [CoordWidth-1:0] nmin_x, nmax_x, nmin_y, nmax_y, nfirst_x, nfirst_y;

   assign req_tready = !(pend_edge_ff || pend_close_ff || pend_box_ff);
   assign accept     = req_tvalid && req_tready;
   assign push_valid = pend_edge_ff || pend_close_ff || pend_box_ff;

   always_comb begin
      nmin_x   = (vertex_x < min_x_ff) ? vertex_x : min_x_ff;
      nmax_x   = (vertex_x > max_x_ff) ? vertex_x : max_x_ff;
      nmin_y   = (vertex_y < min_y_ff) ? vertex_y : min_y_ff;
      nmax_y   = (vertex_y > max_y_ff) ? vertex_y : max_y_ff;
      nfirst_x = (count_ff == 2'd0) ? vertex_x : first_x_ff;
      nfirst_y = (count_ff == 2'd0) ? vertex_y : first_y_ff;

      first_x_in = first_x_ff;  first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;   prev_y_in  = prev_y_ff;
      count_in   = count_ff;
      min_x_in   = min_x_ff;    max_x_in   = max_x_ff;
      min_y_in   = min_y_ff;    max_y_in   = max_y_ff;
      pend_edge_in  = pend_edge_ff;
      pend_close_in = pend_close_ff;
      pend_box_in   = pend_box_ff;
      edge_dx_in  = edge_dx_ff;  edge_dy_in  = edge_dy_ff;
      close_dx_in = close_dx_ff; close_dy_in = close_dy_ff;
      box_l_in = box_l_ff; box_r_in = box_r_ff; box_b_in = box_b_ff; box_t_in = box_t_ff;

      if (accept) begin
         first_x_in  = nfirst_x;
         first_y_in  = nfirst_y;
         prev_x_in   = vertex_x;
         prev_y_in   = vertex_y;
         edge_dx_in  = FieldWidth'(vertex_x) - FieldWidth'(prev_x_ff);
         edge_dy_in  = FieldWidth'(vertex_y) - FieldWidth'(prev_y_ff);
         close_dx_in = FieldWidth'(nfirst_x) - FieldWidth'(vertex_x);
         close_dy_in = FieldWidth'(nfirst_y) - FieldWidth'(vertex_y);
         pend_edge_in  = (count_ff != 2'd0);
         pend_close_in = is_last_vertex && (count_ff != 2'd1);
         pend_box_in   = is_last_vertex;
         if (is_last_vertex) begin
            // Hand the bounds over and start a fresh polygon
            box_l_in = nmin_x; box_r_in = nmax_x; box_b_in = nmin_y; box_t_in = nmax_y;
            min_x_in = MostPos; min_y_in = MostPos;
            max_x_in = MostNeg; max_y_in = MostNeg;
            count_in = 2'd0;
         end else begin
            min_x_in = nmin_x; max_x_in = nmax_x;
            min_y_in = nmin_y; max_y_in = nmax_y;
            count_in = (count_ff == 2'd3) ? 2'd3 : count_ff + 2'd1;
         end
      end else if (push_ready) begin
         // Issue pending jobs in order: edge, closing edge, bounds
         if (pend_edge_ff) begin
            pend_edge_in = 1'b0;
         end else if (pend_close_ff) begin
            pend_close_in = 1'b0;
         end else begin
            pend_box_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (pend_edge_ff) begin
         push_data = {FieldWidth'(0), FieldWidth'(0), edge_dy_ff, edge_dx_ff,
                      pen_pkg::KIND_NORMAL};
      end else if (pend_close_ff) begin
         push_data = {FieldWidth'(0), FieldWidth'(0), close_dy_ff, close_dx_ff,
                      pen_pkg::KIND_NORMAL};
      end else begin
         push_data = {FieldWidth'(box_t_ff), FieldWidth'(box_b_ff),
                      FieldWidth'(box_r_ff), FieldWidth'(box_l_ff), pen_pkg::KIND_BOUNDS};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0; first_y_ff <= '0;
         prev_x_ff  <= '0; prev_y_ff  <= '0;
         count_ff   <= 2'd0;
         min_x_ff   <= MostPos; min_y_ff <= MostPos;
         max_x_ff   <= MostNeg; max_y_ff <= MostNeg;
         pend_edge_ff  <= 1'b0;
         pend_close_ff <= 1'b0;
         pend_box_ff   <= 1'b0;
      end else begin
         first_x_ff <= first_x_in; first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;  prev_y_ff  <= prev_y_in;
         count_ff   <= count_in;
         min_x_ff   <= min_x_in;   min_y_ff   <= min_y_in;
         max_x_ff   <= max_x_in;   max_y_ff   <= max_y_in;
         pend_edge_ff  <= pend_edge_in;
         pend_close_ff <= pend_close_in;
         pend_box_ff   <= pend_box_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_dx_ff  <= edge_dx_in;  edge_dy_ff  <= edge_dy_in;
      close_dx_ff <= close_dx_in; close_dy_ff <= close_dy_in;
      box_l_ff <= box_l_in; box_r_ff <= box_r_in; box_b_ff <= box_b_in; box_t_ff <= box_t_in;
   end
endmodule
`default_nettype wire

// File: rtl/pen_back.sv
// Normal unit: passes bounds jobs on; for edge jobs, squares, then a bit-serial exact rounded unit normal search.
`default_nettype none
module pen_back #(
   parameter int CoordWidth = pen_pkg::COORD_WIDTH,
   parameter int FracBits = pen_pkg::NORMAL_FRAC_BITS,
   localparam int FieldWidth = CoordWidth + 1,
   localparam int JobWidth = 4 * FieldWidth + 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 pop_valid,
   output logic                                      pop_ready,
   input  wire logic [JobWidth-1:0]                  pop_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_kind,
   output logic      [pen_pkg::NORMAL_WIDTH-1:0]     rsp_normal_x,
   output logic      [pen_pkg::NORMAL_WIDTH-1:0]     rsp_normal_y,
   output logic      [pen_pkg::BOX_WIDTH-1:0]        rsp_box_left,
   output logic      [pen_pkg::BOX_WIDTH-1:0]        rsp_box_right,
   output logic      [pen_pkg::BOX_WIDTH-1:0]        rsp_box_bottom,
   output logic      [pen_pkg::BOX_WIDTH-1:0]        rsp_box_top,
   output logic                                      rsp_last
);
   localparam int SqWidth  = 2 * CoordWidth;
   localparam int WideW    = 2 * CoordWidth + 2 * FracBits + 6;
   localparam int MagW     = FracBits + 1;
   localparam int BitW     = $clog2(FracBits + 1);
   localparam int CntW     = $clog2(CoordWidth);
   localparam int ShW      = BitW + 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_PREP   = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_SEND   = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic      [CoordWidth-1:0]   mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic      [SqWidth-1:0]      sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic      [CntW-1:0]         cnt_ff, cnt_in;
   logic signed [WideW-1:0]      s_ff, s_in, lx_ff, lx_in, ly_ff, ly_in;
   logic signed [WideW-1:0]      ax_ff, ax_in, bx_ff, bx_in, ay_ff, ay_in, by_ff, by_in;
   logic      [MagW-1:0]         mx_ff, mx_in, my_ff, my_in;
   logic      [BitW-1:0]         bit_ff, bit_in;
   logic                         kind_ff, kind_in, last_ff, last_in;
   logic      [pen_pkg::NORMAL_WIDTH-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic      [pen_pkg::BOX_WIDTH-1:0]    bl_ff, bl_in, br_ff, br_in, bb_ff, bb_in, bt_ff, bt_in;

   logic signed [FieldWidth-1:0] job_dx, job_dy;
   logic signed [WideW-1:0]      s_sum, cand_x, cand_y;
   logic        [ShW-1:0]        sh_b, sh_s, sh_u;

   assign job_dx    = pop_data[1 +: FieldWidth];
   assign job_dy    = pop_data[1 + FieldWidth +: FieldWidth];
   assign pop_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign rsp_kind       = kind_ff;
   assign rsp_last       = last_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;
   assign rsp_box_left   = bl_ff;
   assign rsp_box_right  = br_ff;
   assign rsp_box_bottom = bb_ff;
   assign rsp_box_top    = bt_ff;

   assign s_sum  = WideW'(sq_x_ff) + WideW'(sq_y_ff);
   assign sh_b   = ShW'(bit_ff) + ShW'(2);
   assign sh_s   = {1'b0, bit_ff, 1'b0} + ShW'(2);
   assign sh_u   = ShW'(bit_ff) + ShW'(1);
   // Trial (2m-1)^2*S for m with the current bit set, from running terms
   assign cand_x = ax_ff + (bx_ff <<< sh_b) + (s_ff <<< sh_s);
   assign cand_y = ay_ff + (by_ff <<< sh_b) + (s_ff <<< sh_s);

   always_comb begin
      state_in = state_ff;
      mag_x_in = mag_x_ff; mag_y_in = mag_y_ff;
      neg_x_in = neg_x_ff; neg_y_in = neg_y_ff;
      sq_x_in = sq_x_ff; sq_y_in = sq_y_ff; cnt_in = cnt_ff;
      s_in = s_ff; lx_in = lx_ff; ly_in = ly_ff;
      ax_in = ax_ff; bx_in = bx_ff; ay_in = ay_ff; by_in = by_ff;
      mx_in = mx_ff; my_in = my_ff; bit_in = bit_ff;
      kind_in = kind_ff; last_in = last_ff; nx_in = nx_ff; ny_in = ny_ff;
      bl_in = bl_ff; br_in = br_ff; bb_in = bb_ff; bt_in = bt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_data[0] == pen_pkg::KIND_BOUNDS) begin
                  kind_in = pen_pkg::KIND_BOUNDS;
                  last_in = 1'b1;
                  nx_in = '0; ny_in = '0;
                  bl_in = pen_pkg::BOX_WIDTH'(pop_data[1 +: FieldWidth]);
                  br_in = pen_pkg::BOX_WIDTH'(pop_data[1 + FieldWidth +: FieldWidth]);
                  bb_in = pen_pkg::BOX_WIDTH'(pop_data[1 + 2 * FieldWidth +: FieldWidth]);
                  bt_in = pen_pkg::BOX_WIDTH'(pop_data[1 + 3 * FieldWidth +: FieldWidth]);
                  state_in = ST_SEND;
               end else begin
                  kind_in  = pen_pkg::KIND_NORMAL;
                  last_in  = 1'b0;
                  bl_in = '0; br_in = '0; bb_in = '0; bt_in = '0;
                  mag_x_in = CoordWidth'(job_dx[CoordWidth] ? -job_dx : job_dx);
                  mag_y_in = CoordWidth'(job_dy[CoordWidth] ? -job_dy : job_dy);
                  neg_x_in = !job_dy[CoordWidth] && (job_dy != '0);
                  neg_y_in = job_dx[CoordWidth];
                  sq_x_in  = '0; sq_y_in = '0; cnt_in = '0;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            // One bit of each magnitude a cycle
            if (mag_x_ff[cnt_ff]) sq_x_in = sq_x_ff + (SqWidth'(mag_x_ff) << cnt_ff);
            if (mag_y_ff[cnt_ff]) sq_y_in = sq_y_ff + (SqWidth'(mag_y_ff) << cnt_ff);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(CoordWidth - 1)) state_in = ST_PREP;
         end
         ST_PREP: begin
            s_in   = s_sum;
            lx_in  = WideW'(sq_y_ff) <<< (2 * FracBits + 2);
            ly_in  = WideW'(sq_x_ff) <<< (2 * FracBits + 2);
            ax_in  = s_sum; ay_in = s_sum;
            bx_in  = -s_sum; by_in = -s_sum;
            mx_in  = '0; my_in = '0;
            bit_in = BitW'(FracBits);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cand_x <= lx_ff) begin
               ax_in = cand_x;
               bx_in = bx_ff + (s_ff <<< sh_u);
               mx_in = mx_ff | (MagW'(1) << bit_ff);
            end
            if (cand_y <= ly_ff) begin
               ay_in = cand_y;
               by_in = by_ff + (s_ff <<< sh_u);
               my_in = my_ff | (MagW'(1) << bit_ff);
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_SEND;
               // Apply the signs; a zero numerator gives zero, which covers zero edges
               nx_in = (mag_y_ff == '0) ? '0 :
                       (neg_x_ff ? -pen_pkg::NORMAL_WIDTH'(mx_in)
                                 : pen_pkg::NORMAL_WIDTH'(mx_in));
               ny_in = (mag_x_ff == '0) ? '0 :
                       (neg_y_ff ? -pen_pkg::NORMAL_WIDTH'(my_in)
                                 : pen_pkg::NORMAL_WIDTH'(my_in));
            end
         end
         ST_SEND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in; mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in; neg_y_ff <= neg_y_in;
      sq_x_ff <= sq_x_in; sq_y_ff <= sq_y_in; cnt_ff <= cnt_in;
      s_ff <= s_in; lx_ff <= lx_in; ly_ff <= ly_in;
      ax_ff <= ax_in; bx_ff <= bx_in; ay_ff <= ay_in; by_ff <= by_in;
      mx_ff <= mx_in; my_ff <= my_in; bit_ff <= bit_in;
      kind_ff <= kind_in; last_ff <= last_in;
      bl_ff <= bl_in; br_ff <= br_in; bb_ff <= bb_in; bt_ff <= bt_in;
      nx_ff <= nx_in; ny_ff <= ny_in;
   end
endmodule
`default_nettype wire

// File: rtl/polygon_edge_normals_and_bounds.sv
// Top level: polygon edge normals in Q2.14 and axis-aligned bounds per polygon.
// Path: a normal job is squared serially, prepared, searched bit by bit and then presented;
// a bounds item is presented in the cycle after its job leaves the queue.
// The normal unit takes no new job from the queue until its result has been accepted;
// the front end takes no new vertex until it has handed every job it issues to the queue.
// Reset: synchronous, clears polygon state, bounds, queue and the output stage.
`default_nettype none
module polygon_edge_normals_and_bounds #(
   parameter int COORD_WIDTH = pen_pkg::COORD_WIDTH,
   parameter int NORMAL_FRAC_BITS = pen_pkg::NORMAL_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] vertex_x, [63:32] vertex_y
   input  wire logic [pen_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] normal_x, [31:16] normal_y, [63:32] box_left, [95:64] box_right,
   // [127:96] box_bottom, [159:128] box_top
   output logic      [pen_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // [0] result_kind
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);
   localparam int FieldWidth = COORD_WIDTH + 1;
   localparam int JobWidth   = 4 * FieldWidth + 1;

   logic signed [COORD_WIDTH-1:0] vertex_x, vertex_y;
   logic                          push_valid, push_ready, pop_valid, pop_ready;
   logic [JobWidth-1:0]           push_data, pop_data;
   logic [pen_pkg::NORMAL_WIDTH-1:0] normal_x, normal_y;
   logic [pen_pkg::BOX_WIDTH-1:0]    box_left, box_right, box_bottom, box_top;

   // Take coordinates at the working width, sign-extending or dropping high bits
   assign vertex_x = COORD_WIDTH'($signed(req_tdata[pen_pkg::VERTEX_WIDTH-1:0]));
   assign vertex_y = COORD_WIDTH'($signed(req_tdata[pen_pkg::REQ_TDATA_WIDTH-1:
                                                    pen_pkg::VERTEX_WIDTH]));

   pen_front #(.CoordWidth(COORD_WIDTH)) u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .vertex_x, .vertex_y, .is_last_vertex(req_tlast),
      .push_valid, .push_ready, .push_data
   );

   pen_queue #(.Width(JobWidth)) u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_data,
      .pop_valid, .pop_ready, .pop_data
   );

   pen_back #(.CoordWidth(COORD_WIDTH), .FracBits(NORMAL_FRAC_BITS)) u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_data,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_kind(rsp_tuser),
      .rsp_normal_x(normal_x), .rsp_normal_y(normal_y),
      .rsp_box_left(box_left), .rsp_box_right(box_right),
      .rsp_box_bottom(box_bottom), .rsp_box_top(box_top),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {box_top, box_bottom, box_right, box_left, normal_y, normal_x};
endmodule
`default_nettype wire

// File: rtl/pen_checker.sv
// Port-level checks for the polygon edge normal and bounds block.
`default_nettype none
module pen_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [159:0] rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast
);
   // Bounds items, and only they, close a polygon
   a_last_on_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("last mark does not match result kind");

   // Normal items carry no bounds
   a_normal_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pen_pkg::KIND_NORMAL) |-> (rsp_tdata[159:32] == '0))
      else $error("normal item carries bounds");

   // Bounds items carry no normal
   a_box_normal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pen_pkg::KIND_BOUNDS) |-> (rsp_tdata[31:0] == '0))
      else $error("bounds item carries a normal");

   // A stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled item changed");
endmodule

bind polygon_edge_normals_and_bounds pen_checker u_pen_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the polygon edge normal and bounds block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [pen_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pen_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   int error_count = 0;
   int cycle_count = 0;
   bit stim_done = 1'b0;

   typedef struct packed {
      logic                 kind;
      logic signed [15:0]   nx;
      logic signed [15:0]   ny;
      logic signed [31:0]   left;
      logic signed [31:0]   right;
      logic signed [31:0]   bottom;
      logic signed [31:0]   top;
      logic                 last;
   } polygon_result_type;

   polygon_edge_normals_and_bounds dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("error at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Polygon tracker: holds first/previous vertex and running bounds, and queues
   // the normals and bounds each vertex should produce.
   class polygon_tracker;
      polygon_result_type pending[$];
      logic signed [31:0] first_x, first_y, prev_x, prev_y;
      logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
      int count;

      function void clear_box();
         lo_x = 32'sh7fffffff; lo_y = 32'sh7fffffff;
         hi_x = 32'sh80000000; hi_y = 32'sh80000000;
      endfunction

      function new();
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; count = 0;
         clear_box();
      endfunction

      // nearest integer to num*2^F/sqrt(num^2+other^2), ties up
      static function longint unsigned unit_component(longint unsigned num,
                                                      longint unsigned other);
         logic [191:0] lhs, sum, t;
         longint unsigned lo, hi, mid;
         if (num == 0) return 0;
         lo = 0;
         hi = 64'd1 << pen_pkg::NORMAL_FRAC_BITS;
         lhs = (192'(num) * 2) << pen_pkg::NORMAL_FRAC_BITS;
         lhs = lhs * lhs;
         sum = 192'(num) * 192'(num) + 192'(other) * 192'(other);
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 192'(2 * mid - 1);
            if (lhs >= t * t * sum) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void push_normal(longint fx, longint fy, longint tx, longint ty);
         polygon_result_type r;
         longint ex, ey;
         longint unsigned ax, ay, nx, ny;
         ex = tx - fx;
         ey = ty - fy;
         ax = ex < 0 ? -ex : ex;
         ay = ey < 0 ? -ey : ey;
         nx = unit_component(ay, ax);
         ny = unit_component(ax, ay);
         if (ey > 0) nx = -nx;
         if (ex < 0) ny = -ny;
         r = '0;
         r.kind = pen_pkg::KIND_NORMAL;
         r.nx = nx[15:0];
         r.ny = ny[15:0];
         pending.insert(pending.size(), r);
      endfunction

      function void note_vertex(logic signed [31:0] x, logic signed [31:0] y, logic is_last);
         polygon_result_type r;
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
         if (count == 0) begin
            first_x = x; first_y = y;
         end else begin
            push_normal(prev_x, prev_y, x, y);
         end
         if (is_last) begin
            if (count != 1) push_normal(x, y, first_x, first_y);
            r = '0;
            r.kind = pen_pkg::KIND_BOUNDS;
            r.left = lo_x; r.right = hi_x; r.bottom = lo_y; r.top = hi_y;
            r.last = 1'b1;
            pending.insert(pending.size(), r);
            count = 0;
            clear_box();
         end else if (count < 3) begin
            count++;
         end
         prev_x = x; prev_y = y;
      endfunction

      task check_result(polygon_result_type got);
         polygon_result_type want;
         if (pending.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
         if (got.nx !== want.nx) report($sformatf("normal_x %0d want %0d", got.nx, want.nx));
         if (got.ny !== want.ny) report($sformatf("normal_y %0d want %0d", got.ny, want.ny));
         if (got.left !== want.left) report($sformatf("box_left %0h want %0h", got.left, want.left));
         if (got.right !== want.right)
            report($sformatf("box_right %0h want %0h", got.right, want.right));
         if (got.bottom !== want.bottom)
            report($sformatf("box_bottom %0h want %0h", got.bottom, want.bottom));
         if (got.top !== want.top) report($sformatf("box_top %0h want %0h", got.top, want.top));
         if (got.last !== want.last) report($sformatf("tlast %0d want %0d", got.last, want.last));
      endtask
   endclass

   polygon_tracker tracker = new();

   // Count cycles and stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("polygon_edge_normals_and_bounds: mismatch");
         $finish;
      end
   end

   // Result side: check every accepted item, stall at random per item.
   initial begin : result_side
      int gap;
      polygon_result_type got;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
         got.kind = rsp_tuser;
         got.nx = rsp_tdata[15:0];
         got.ny = rsp_tdata[31:16];
         got.left = rsp_tdata[63:32];
         got.right = rsp_tdata[95:64];
         got.bottom = rsp_tdata[127:96];
         got.top = rsp_tdata[159:128];
         got.last = rsp_tlast;
         tracker.check_result(got);
      end
   end

   // Send one vertex, waiting a random gap first unless told not to.
   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input logic is_last,
                              input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tlast <= is_last;
      @(posedge clock iff req_tready);
      tracker.note_vertex(x, y, is_last);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 20)) - 10);
      endcase
   endfunction

   initial begin : stimulus
      int n, sides, mode;
      bit burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single vertex, two-vertex polygon, unit square, zero-length edge.
      send_vertex(32'h0001_0000, 32'h0002_0000, 1'b1, 0);
      send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0, 0);
      send_vertex(32'h0003_0000, 32'h0004_0000, 1'b1, 0);
      send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0, 1);
      send_vertex(32'h0001_0000, 32'h0000_0000, 1'b0, 1);
      send_vertex(32'h0001_0000, 32'h0001_0000, 1'b0, 1);
      send_vertex(32'h0001_0000, 32'h0001_0000, 1'b0, 1);
      send_vertex(32'h0000_0000, 32'h0001_0000, 1'b1, 1);
      // Coordinate extremes: full-range edges in several directions, then a small triangle and a lone vertex.
      send_vertex(32'h7fffffff, 32'h80000000, 1'b0, 0);
      send_vertex(32'h80000000, 32'h7fffffff, 1'b0, 0);
      send_vertex(32'h80000000, 32'h80000000, 1'b0, 0);
      send_vertex(32'h7fffffff, 32'h7fffffff, 1'b1, 0);
      send_vertex(32'hffffffff, 32'h00000001, 1'b0, 0);
      send_vertex(32'h00000001, 32'hffffffff, 1'b0, 0);
      send_vertex(32'h00000001, 32'h00000002, 1'b1, 0);
      send_vertex(32'h5555aaaa, 32'haaaa5555, 1'b1, 0);

      // Hold the sender until everything has drained.
      end_burst();
      wait (tracker.pending.size() == 0);
      @(posedge clock);

      // Random polygons of varied size, content and spacing.
      n = 0;
      while (n < 104) begin
         sides = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         mode = $urandom_range(0, 3);
         burst = $urandom_range(0, 2) == 0;
         for (int i = 0; i < sides; i++) begin
            send_vertex(random_coord(mode), random_coord(mode), i == sides - 1, burst);
            n++;
         end
         if ($urandom_range(0, 9) == 0) begin
            end_burst();
            wait (tracker.pending.size() == 0);
            @(posedge clock);
         end
      end
      end_burst();
      stim_done = 1'b1;
   end

   initial begin : finish_run
      wait (stim_done && tracker.pending.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && tracker.pending.size() == 0) begin
         $display("polygon_edge_normals_and_bounds: match");
      end else begin
         $display("polygon_edge_normals_and_bounds: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/pen_pkg.sv
rtl/pen_queue.sv
rtl/pen_front.sv
rtl/pen_back.sv
rtl/polygon_edge_normals_and_bounds.sv
rtl/pen_checker.sv
bench/tb.sv
